// ----- hw/rtl/contiguous_block_allocator_defines.svh -----
// Assertion macros for the contiguous block allocator.
// Uses the clk and rst signals of the module that includes it.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH

// Condition that holds at every edge outside reset.
`define CBA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that holds in the cycle after a trigger.
`define CBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cba_pkg.sv -----
// Package for the contiguous block allocator: sizes, codes and types.
// No dependencies.
package cba_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int PTR_W      = $clog2(NUM_BLOCKS + 1);
  localparam int FIELD_W    = 6;
  localparam int LEN_W      = 7;
  localparam int STAT_W     = 3;
  localparam int WORD_W     = STAT_W + IDX_W;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_FREE = 3'd0;
  localparam status_t ST_ONE  = 3'd1;
  localparam status_t ST_HEAD = 3'd2;
  localparam status_t ST_MID  = 3'd3;
  localparam status_t ST_TAIL = 3'd4;

  typedef enum logic [1:0] {
    K_RESERVE = 2'd0,
    K_FREE    = 2'd1,
    K_DEFRAG  = 2'd2,
    K_NONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT, S_RS_RD, S_RS_EV, S_HS, S_MARK,
    S_FR_RD, S_FR_EV, S_DF_RD, S_DF_EV, S_DF_END
  } state_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] handle;
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic [PTR_W-1:0] len;
    logic             last;
  } res_t;

endpackage

// ----- hw/rtl/contiguous_block_allocator.sv -----
// Contiguous block allocator top level: control sequencer over the block RAM.
// Depends on cba_pkg, cba_ram and contiguous_block_allocator_defines.svh.
//
// Usage:
//  Input channel (in_valid/in_stall) carries one word: kind, count, block_index.
//  kind 0 reserves count blocks, 1 frees the run starting at block_index,
//  2 compacts all live runs toward block 0, 3 is a no-op with a failure reply.
//  Output channel (out_valid/out_stall) returns one word per reserve/free/no-op,
//  and one move word per live run for compaction (one empty word if none);
//  last marks the final word of each request.
//  Only one request is in flight; in_stall is low only while the sequencer
//  is idle. Each table entry is handled as a RAM read, then an evaluate step.
//  Reserve: a scan of the table for a free run, a handle search and a
//  marking pass over the run. Free: a read and evaluate per block of the run.
//  Compaction: a scan of the whole table, then retiring the tail; each move
//  word adds its hand-off and any output waits. Each reply goes via S_EMIT.
//  A result sits in the output register until taken; a stalled receiver
//  holds back the next result and thus the sequencer.
//  Reset (synchronous, rst high) empties the table and frees all handles
//  together; no clearing pass is needed.
module contiguous_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   kind,
  input  logic [cba_pkg::LEN_W-1:0]    count,
  input  logic [cba_pkg::FIELD_W-1:0]  block_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [cba_pkg::FIELD_W-1:0]  handle,
  output logic [cba_pkg::FIELD_W-1:0]  start_block,
  output logic [cba_pkg::FIELD_W-1:0]  move_source,
  output logic [cba_pkg::FIELD_W-1:0]  move_dest,
  output logic [cba_pkg::LEN_W-1:0]    move_length,
  output logic                         last
);
  import cba_pkg::*;

  `include "contiguous_block_allocator_defines.svh"

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(NUM_BLOCKS - 1);
  localparam logic [PTR_W-1:0] N_PTR    = PTR_W'(NUM_BLOCKS);
  localparam res_t RES_FAIL = '{ok: 1'b0, handle: '0, start: '0, src: '0, dst: '0,
                                len: '0, last: 1'b1};

  state_t state, state_next, ret, ret_next;
  res_t   res, res_next, outr, outr_next, pend, pend_next;
  logic   out_v, out_v_next, pend_v, pend_v_next, in_run, in_run_next;
  logic   first, first_next, rvq;
  logic [PTR_W-1:0] cnt, cnt_next, ptr, ptr_next, run, run_next;
  logic [PTR_W-1:0] hcnt, hcnt_next, wptr, wptr_next, rem, rem_next;
  logic [PTR_W-1:0] rlen, rlen_next;
  logic [IDX_W-1:0] start, start_next, rsrc, rsrc_next, rdst, rdst_next;
  logic [IDX_W-1:0] rh, rh_next;
  logic [NUM_BLOCKS-1:0] svalid, svalid_next, hv, hv_next;

  logic              ram_we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  status_t           st, mark_st;
  logic [IDX_W-1:0]  own;

  cba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign st  = rvq ? rdata[WORD_W-1:IDX_W] : ST_FREE;
  assign own = rdata[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      out_v  <= 1'b0;
      pend_v <= 1'b0;
      in_run <= 1'b0;
      svalid <= '0;
      hv     <= '0;
    end else begin
      state  <= state_next;
      out_v  <= out_v_next;
      pend_v <= pend_v_next;
      in_run <= in_run_next;
      svalid <= svalid_next;
      hv     <= hv_next;
    end
  end

  always_ff @(posedge clk) begin
    ret   <= ret_next;
    res   <= res_next;
    outr  <= outr_next;
    pend  <= pend_next;
    first <= first_next;
    cnt   <= cnt_next;
    ptr   <= ptr_next;
    run   <= run_next;
    hcnt  <= hcnt_next;
    wptr  <= wptr_next;
    rem   <= rem_next;
    rlen  <= rlen_next;
    start <= start_next;
    rsrc  <= rsrc_next;
    rdst  <= rdst_next;
    rh    <= rh_next;
    rvq   <= svalid[raddr];
  end

  always_comb begin
    if (cnt == PTR_W'(1)) begin
      mark_st = ST_ONE;
    end else if (rem == '0) begin
      mark_st = ST_HEAD;
    end else if (rem == cnt - PTR_W'(1)) begin
      mark_st = ST_TAIL;
    end else begin
      mark_st = ST_MID;
    end
  end

  always_comb begin
    res_t   nres;
    logic   done_run;
    state_t nxt;
    state_next  = state;
    ret_next    = ret;
    res_next    = res;
    outr_next   = outr;
    out_v_next  = out_v;
    pend_next   = pend;
    pend_v_next = pend_v;
    in_run_next = in_run;
    first_next  = first;
    cnt_next    = cnt;
    ptr_next    = ptr;
    run_next    = run;
    hcnt_next   = hcnt;
    wptr_next   = wptr;
    rem_next    = rem;
    rlen_next   = rlen;
    start_next  = start;
    rsrc_next   = rsrc;
    rdst_next   = rdst;
    rh_next     = rh;
    svalid_next = svalid;
    hv_next     = hv;
    ram_we      = 1'b0;
    waddr       = wptr[IDX_W-1:0];
    wdata       = rdata;
    raddr       = ptr[IDX_W-1:0];
    in_stall    = 1'b1;
    nres        = '0;
    done_run    = 1'b0;
    nxt         = S_DF_RD;

    if (out_v && !out_stall) begin
      out_v_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (kind)
            K_RESERVE: begin
              if (count == '0 || count > LEN_W'(NUM_BLOCKS)) begin
                res_next   = RES_FAIL;
                ret_next   = S_IDLE;
                state_next = S_EMIT;
              end else begin
                cnt_next   = PTR_W'(count);
                ptr_next   = '0;
                run_next   = '0;
                state_next = S_RS_RD;
              end
            end
            K_FREE: begin
              if (LEN_W'(block_index) >= LEN_W'(NUM_BLOCKS)) begin
                res_next   = RES_FAIL;
                ret_next   = S_IDLE;
                state_next = S_EMIT;
              end else begin
                ptr_next   = PTR_W'(block_index);
                first_next = 1'b1;
                state_next = S_FR_RD;
              end
            end
            K_DEFRAG: begin
              ptr_next    = '0;
              wptr_next   = '0;
              pend_v_next = 1'b0;
              in_run_next = 1'b0;
              state_next  = S_DF_RD;
            end
            default: begin
              res_next   = RES_FAIL;
              ret_next   = S_IDLE;
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (!out_v || !out_stall) begin
          outr_next  = res;
          out_v_next = 1'b1;
          state_next = ret;
        end
      end

      S_RS_RD: state_next = S_RS_EV;

      S_RS_EV: begin
        if (st == ST_FREE && run == cnt - PTR_W'(1)) begin
          if (run == '0) begin
            start_next = ptr[IDX_W-1:0];
          end
          hcnt_next  = '0;
          state_next = S_HS;
        end else begin
          if (st != ST_FREE) begin
            run_next = '0;
          end else begin
            if (run == '0) begin
              start_next = ptr[IDX_W-1:0];
            end
            run_next = run + PTR_W'(1);
          end
          if (ptr == LAST_IDX) begin
            res_next   = RES_FAIL;
            ret_next   = S_IDLE;
            state_next = S_EMIT;
          end else begin
            ptr_next   = ptr + PTR_W'(1);
            state_next = S_RS_RD;
          end
        end
      end

      S_HS: begin
        if (hcnt == N_PTR) begin
          res_next   = RES_FAIL;
          ret_next   = S_IDLE;
          state_next = S_EMIT;
        end else if (!hv[hcnt[IDX_W-1:0]]) begin
          wptr_next  = PTR_W'(start);
          rem_next   = '0;
          state_next = S_MARK;
        end else begin
          hcnt_next = hcnt + PTR_W'(1);
        end
      end

      S_MARK: begin
        ram_we = 1'b1;
        wdata  = {mark_st, (rem == '0) ? hcnt[IDX_W-1:0] : IDX_W'(0)};
        svalid_next[wptr[IDX_W-1:0]] = 1'b1;
        if (rem == cnt - PTR_W'(1)) begin
          hv_next[hcnt[IDX_W-1:0]] = 1'b1;
          res_next        = RES_FAIL;
          res_next.ok     = 1'b1;
          res_next.handle = hcnt[IDX_W-1:0];
          res_next.start  = start;
          ret_next        = S_IDLE;
          state_next      = S_EMIT;
        end else begin
          rem_next  = rem + PTR_W'(1);
          wptr_next = wptr + PTR_W'(1);
        end
      end

      S_FR_RD: state_next = S_FR_EV;

      S_FR_EV: begin
        if (first && st != ST_ONE && st != ST_HEAD) begin
          res_next   = RES_FAIL;
          ret_next   = S_IDLE;
          state_next = S_EMIT;
        end else begin
          svalid_next[ptr[IDX_W-1:0]] = 1'b0;
          if (first) begin
            hv_next[own] = 1'b0;
          end
          first_next = 1'b0;
          if ((first && st == ST_ONE) || (!first && st == ST_TAIL) || ptr == LAST_IDX) begin
            res_next    = RES_FAIL;
            res_next.ok = 1'b1;
            ret_next    = S_IDLE;
            state_next  = S_EMIT;
          end else begin
            ptr_next   = ptr + PTR_W'(1);
            state_next = S_FR_RD;
          end
        end
      end

      S_DF_RD: state_next = S_DF_EV;

      S_DF_EV: begin
        nxt = (ptr == LAST_IDX) ? S_DF_END : S_DF_RD;
        nres.ok = 1'b1;
        if (in_run || st != ST_FREE) begin
          ram_we = 1'b1;
          svalid_next[wptr[IDX_W-1:0]] = 1'b1;
          wptr_next = wptr + PTR_W'(1);
        end
        if (!in_run) begin
          nres.src    = ptr[IDX_W-1:0];
          nres.dst    = wptr[IDX_W-1:0];
          nres.handle = own;
          nres.len    = PTR_W'(1);
          rsrc_next   = ptr[IDX_W-1:0];
          rdst_next   = wptr[IDX_W-1:0];
          rh_next     = own;
          rlen_next   = PTR_W'(1);
          if (st != ST_FREE) begin
            if (st == ST_HEAD && ptr != LAST_IDX) begin
              in_run_next = 1'b1;
            end else begin
              done_run = 1'b1;
            end
          end
        end else begin
          nres.src    = rsrc;
          nres.dst    = rdst;
          nres.handle = rh;
          nres.len    = rlen + PTR_W'(1);
          rlen_next   = rlen + PTR_W'(1);
          if (st == ST_TAIL || ptr == LAST_IDX) begin
            in_run_next = 1'b0;
            done_run    = 1'b1;
          end
        end
        ptr_next   = ptr + PTR_W'(1);
        state_next = nxt;
        if (done_run) begin
          pend_next   = nres;
          pend_v_next = 1'b1;
          if (pend_v) begin
            res_next   = pend;
            ret_next   = nxt;
            state_next = S_EMIT;
          end
        end
      end

      S_DF_END: begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          if (PTR_W'(i) >= wptr) begin
            svalid_next[i] = 1'b0;
          end
        end
        if (pend_v) begin
          res_next = pend;
        end else begin
          res_next = RES_FAIL;
          res_next.ok = 1'b1;
        end
        res_next.last = 1'b1;
        pend_v_next   = 1'b0;
        ret_next      = S_IDLE;
        state_next    = S_EMIT;
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid   = out_v;
  assign ok          = outr.ok;
  assign handle      = FIELD_W'(outr.handle);
  assign start_block = FIELD_W'(outr.start);
  assign move_source = FIELD_W'(outr.src);
  assign move_dest   = FIELD_W'(outr.dst);
  assign move_length = LEN_W'(outr.len);
  assign last        = outr.last;

  `CBA_ASSERT(a_df_order, (state != S_DF_EV) || (wptr <= ptr), "compaction write passed read")
  `CBA_ASSERT(a_mark_free_handle, (state != S_MARK) || !hv[hcnt[IDX_W-1:0]], "handle in use")
  `CBA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state != S_IDLE, "accepted word lost")
  `CBA_ASSERT_NEXT(a_mark_binds, state == S_MARK && rem == cnt - PTR_W'(1),
                   hv[$past(hcnt[IDX_W-1:0])], "reserved handle not bound")

endmodule

// ----- hw/rtl/cba_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
